### sv/ifr_pkg.sv
// Shared codes, field widths and control types of the idle-timeout frame receiver.
`default_nettype none

package ifr_pkg;

  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned IDX_IN_W  = 6;
  localparam int unsigned LEN_OUT_W = 6;
  localparam int unsigned TICK_W    = 16;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd5;

  // transaction function codes
  localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  typedef struct packed {
    logic wr_en;   // store one received byte and the new slot length
    logic rd_en;   // capture read data for the accepted transaction
    logic rd_ok;   // read slot and index are in range
  } store_ctl_t;

endpackage

`default_nettype wire

### sv/ifr_frame_store.sv
// Frame byte memory and per-slot length table of the frame receiver.
`default_nettype none

module ifr_frame_store #(
  parameter int unsigned SLOTS        = 2,
  parameter int unsigned BUFFER_BYTES = 64,
  parameter int unsigned SW           = $clog2(SLOTS),
  parameter int unsigned IW           = $clog2(BUFFER_BYTES),
  parameter int unsigned LW           = $clog2(BUFFER_BYTES)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ifr_pkg::store_ctl_t          ctl,
  input  wire logic [SW-1:0]                wr_slot,
  input  wire logic [IW-1:0]                wr_pos,
  input  wire logic [LW-1:0]                wr_len,
  input  wire logic [ifr_pkg::BYTE_W-1:0]   wr_byte,
  input  wire logic [SW-1:0]                rd_slot,
  input  wire logic [IW-1:0]                rd_idx,
  output logic      [ifr_pkg::BYTE_W-1:0]   rd_data,
  output logic      [LW-1:0]                rd_len
);

  localparam int unsigned DEPTH = SLOTS * BUFFER_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [ifr_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [ifr_pkg::BYTE_W-1:0] mem_q_r;
  logic                       rd_ok_r;
  logic [LW-1:0]              len_r [SLOTS];

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_addr = AW'(wr_slot) * AW'(BUFFER_BYTES) + AW'(wr_pos);
  assign rd_addr = AW'(rd_slot) * AW'(BUFFER_BYTES) + AW'(rd_idx);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_byte;
    end
    if (ctl.rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
      for (int i = 0; i < int'(SLOTS); i++) begin
        len_r[i] <= '0;
      end
    end else begin
      if (ctl.rd_en) begin
        rd_ok_r <= ctl.rd_ok;
      end
      if (ctl.wr_en) begin
        len_r[wr_slot] <= wr_len;
      end
    end
  end

  assign rd_data = rd_ok_r ? mem_q_r : '0;
  // caller gates this when rd_slot is out of range
  assign rd_len  = len_r[rd_slot];

endmodule

`default_nettype wire

### sv/idle_timeout_frame_receiver_top.sv
// Top level of the idle-timeout frame receiver: control, state and result register.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | func, rx_byte, read_slot, read_index
//  out_    | output    | out_valid/out_stall| frame_done, done_slot, done_length,
//          |           |                    | read_data, read_length, receiving
//  cfg_    | input     | cfg_wr_en          | cfg_wr_data (idle timeout ticks)
//
// One transaction per cycle while in_stall is low; each result is registered and appears
// in the cycle after acceptance, read data via the frame byte memory's registered port.
// Synchronous active-low reset clears control, counters and slot lengths; frame
// bytes stay undefined until written.
// in_stall is high only while a result is held and out_stall is high.
`default_nettype none

module idle_timeout_frame_receiver_top #(
  parameter int unsigned SLOTS        = 2,
  parameter int unsigned BUFFER_BYTES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [ifr_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [ifr_pkg::BYTE_W-1:0]      in_rx_byte,
  input  wire logic                            in_read_slot,
  input  wire logic [ifr_pkg::IDX_IN_W-1:0]    in_read_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_frame_done,
  output logic                                 out_done_slot,
  output logic      [ifr_pkg::LEN_OUT_W-1:0]   out_done_length,
  output logic      [ifr_pkg::BYTE_W-1:0]      out_read_data,
  output logic      [ifr_pkg::LEN_OUT_W-1:0]   out_read_length,
  output logic                                 out_receiving,
  input  wire logic                            cfg_wr_en,
  input  wire logic [ifr_pkg::TICK_W-1:0]      cfg_wr_data
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned IW = $clog2(BUFFER_BYTES);
  localparam int unsigned LW = $clog2(BUFFER_BYTES);
  localparam logic [LW-1:0] LEN_MAX  = LW'(BUFFER_BYTES - 1);
  localparam logic [SW-1:0] SLOT_MAX = SW'(SLOTS - 1);

  logic [ifr_pkg::TICK_W-1:0] timeout_r;
  logic                       rcv_r, rcv_nxt;
  logic [ifr_pkg::TICK_W-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]              slot_r, slot_nxt;
  logic [LW-1:0]              len_r, len_nxt;

  logic                            out_valid_r;
  logic                            done_r;
  logic                            dslot_r;
  logic [ifr_pkg::LEN_OUT_W-1:0]   dlen_r;
  logic [ifr_pkg::LEN_OUT_W-1:0]   rlen_r;
  logic                            orcv_r;

  logic acc;
  logic is_byte, is_tick, is_read;
  logic [LW-1:0] base_len, new_len;
  logic [ifr_pkg::TICK_W-1:0] cnt_inc;
  logic close;
  logic slot_ok, idx_ok;

  ifr_pkg::store_ctl_t        st_ctl;
  logic [ifr_pkg::BYTE_W-1:0] st_rd_data;
  logic [LW-1:0]              st_rd_len;

  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;

  assign is_byte = (in_func == ifr_pkg::FUNC_BYTE);
  assign is_tick = (in_func == ifr_pkg::FUNC_TICK);
  assign is_read = (in_func == ifr_pkg::FUNC_READ);

  // a byte while idle opens a new frame at length zero
  assign base_len = rcv_r ? len_r : '0;
  assign new_len  = (base_len == LEN_MAX) ? base_len : base_len + 1'b1;

  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
  assign close   = is_tick & rcv_r & (cnt_inc >= timeout_r);

  assign slot_ok = (32'(in_read_slot) < SLOTS);
  assign idx_ok  = (32'(in_read_index) < BUFFER_BYTES);

  always_comb begin
    rcv_nxt  = rcv_r;
    cnt_nxt  = cnt_r;
    slot_nxt = slot_r;
    len_nxt  = len_r;
    if (acc) begin
      if (is_byte) begin
        rcv_nxt = 1'b1;
        cnt_nxt = '0;
        len_nxt = new_len;
      end else if (is_tick && rcv_r) begin
        cnt_nxt = cnt_inc;
        if (close) begin
          rcv_nxt  = 1'b0;
          slot_nxt = (slot_r == SLOT_MAX) ? '0 : slot_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= ifr_pkg::TIMEOUT_RESET;
      rcv_r       <= 1'b0;
      cnt_r       <= '0;
      slot_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      rcv_r       <= rcv_nxt;
      cnt_r       <= cnt_nxt;
      slot_r      <= slot_nxt;
      len_r       <= len_nxt;
      out_valid_r <= acc | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      done_r  <= close;
      dslot_r <= close ? slot_r[0] : 1'b0;
      dlen_r  <= close ? ifr_pkg::LEN_OUT_W'(len_r) : '0;
      rlen_r  <= (is_read && slot_ok) ? ifr_pkg::LEN_OUT_W'(st_rd_len) : '0;
      orcv_r  <= rcv_nxt;
    end
  end

  assign st_ctl.wr_en = acc & is_byte;
  assign st_ctl.rd_en = acc;
  assign st_ctl.rd_ok = is_read & slot_ok & idx_ok;

  ifr_frame_store #(
    .SLOTS        (SLOTS),
    .BUFFER_BYTES (BUFFER_BYTES),
    .SW           (SW),
    .IW           (IW),
    .LW           (LW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (st_ctl),
    .wr_slot (slot_r),
    .wr_pos  (IW'(base_len)),
    .wr_len  (new_len),
    .wr_byte (in_rx_byte),
    .rd_slot (SW'(in_read_slot)),
    .rd_idx  (IW'(in_read_index)),
    .rd_data (st_rd_data),
    .rd_len  (st_rd_len)
  );

  assign out_valid       = out_valid_r;
  assign out_frame_done  = done_r;
  assign out_done_slot   = dslot_r;
  assign out_done_length = dlen_r;
  assign out_read_data   = st_rd_data;
  assign out_read_length = rlen_r;
  assign out_receiving   = orcv_r;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_done |-> !out_receiving)
    else $error("frame done reported while still receiving");

  a_byte_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_byte |=> cnt_r == '0 && rcv_r)
    else $error("received byte did not restart idle count");

  a_close_advances: assert property (@(posedge clk) disable iff (!rst_n)
    acc && close |=> !rcv_r && slot_r != $past(slot_r))
    else $error("frame close did not advance slot");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(slot_r) < SLOTS)
    else $error("current slot out of range");

  a_no_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !acc)
    else $error("transaction accepted while result held");
`endif

endmodule

`default_nettype wire
